// ----- src/bsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg - shared types and constants for the Booth multiplier
// Operand width and the per-cell pipeline word.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int unsigned Width = 8;

  // one in-flight item as it moves down the chain of cells
  typedef struct packed {
    logic             valid;
    logic [Width-1:0] mcand;  // multiplicand, travels unchanged
    logic [Width-1:0] acc;    // upper half of the partial product
    logic [Width-1:0] mplr;   // multiplier bits / lower half of the product
    logic             qm1;    // extra bit right of the multiplier LSB
  } stage_t;

endpackage

// ----- src/bsm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_cell - one Booth recoding step
// Adds, subtracts or skips the multiplicand, then shifts {acc, mplr, qm1}
// right arithmetically and registers the result for the next cell.
// ----------------------------------------------------------------------------
module bsm_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bsm_pkg::stage_t stage_i,
  output bsm_pkg::stage_t stage_o
);

  bsm_pkg::stage_t                 stage_d;
  bsm_pkg::stage_t                 stage_q;
  logic [bsm_pkg::Width-1:0]       sum;

  always_comb begin
    case ({stage_i.mplr[0], stage_i.qm1})
      2'b10:   sum = stage_i.acc - stage_i.mcand;
      2'b01:   sum = stage_i.acc + stage_i.mcand;
      default: sum = stage_i.acc;
    endcase

    stage_d       = stage_i;
    stage_d.qm1   = stage_i.mplr[0];
    stage_d.mplr  = {sum[0], stage_i.mplr[bsm_pkg::Width-1:1]};
    stage_d.acc   = {sum[bsm_pkg::Width-1], sum[bsm_pkg::Width-1:1]};
  end

  // reset clears valid and the payload alike
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q.valid == $past(stage_i.valid))
    else $error("cell valid does not follow its input");

  a_qm1_from_lsb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_i.valid |=> stage_q.qm1 == $past(stage_i.mplr[0]))
    else $error("extra bit is not the shifted-out multiplier LSB");

  a_mcand_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_i.valid |=> stage_q.mcand == $past(stage_i.mcand))
    else $error("multiplicand changed inside a cell");

endmodule

// ----- src/booth_signed_multiplier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// booth_signed_multiplier_top - signed radix-2 Booth multiplier
// Pipelined chain of Booth cells, one recoding step per cell.
// ----------------------------------------------------------------------------
// Usage: the block takes one operand pair in every clock cycle; busy_o is
// always low, so a transfer happens at every edge with start_i high. Each
// pair runs through a chain of Width cells (8 for the 8-bit build), one
// cell per Booth step, each with its own register, so the product follows
// the transfer, marked by done_o for one cycle, in issue order. The
// receiver cannot stall the block and none is needed: the chain advances
// every cycle and never holds a result back. The accumulator is Width bits
// wide and wraps, so a most-negative multiplicand gives the wrapped register
// content rather than the true product. Latency is set by the cell count.
// ----------------------------------------------------------------------------
module booth_signed_multiplier_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [bsm_pkg::Width-1:0]  multiplicand_i,
  input  logic signed [bsm_pkg::Width-1:0]  multiplier_i,
  output logic                              done_o,
  output logic signed [2*bsm_pkg::Width-1:0] product_o
);

  // stage[k] is the input of cell k; stage[Width] is the last cell's output
  bsm_pkg::stage_t stage [bsm_pkg::Width+1];
  bsm_pkg::stage_t seed;

  // the chain never stalls, so a new pair is always welcome
  assign busy_o = 1'b0;

  // seed the chain: accumulator and extra bit start at zero
  always_comb begin
    seed.valid = start_i & ~busy_o;
    seed.mcand = multiplicand_i;
    seed.acc   = '0;
    seed.mplr  = multiplier_i;
    seed.qm1   = 1'b0;
  end

  assign stage[0] = seed;

  for (genvar k = 0; k < bsm_pkg::Width; k++) begin : g_cell
    bsm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage[k]),
      .stage_o (stage[k+1])
    );
  end

  // the final {acc, mplr} pair is the product; drop the extra bit
  assign done_o    = stage[bsm_pkg::Width].valid;
  assign product_o = {stage[bsm_pkg::Width].acc, stage[bsm_pkg::Width].mplr};

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("multiplier reported busy");

  a_last_cell_fed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(stage[bsm_pkg::Width-1].valid))
    else $error("result without an item in the last cell");

  a_zero_mplr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage[bsm_pkg::Width-1].valid && stage[bsm_pkg::Width-1].acc == '0 &&
     stage[bsm_pkg::Width-1].mplr[0] == stage[bsm_pkg::Width-1].qm1)
    |=> product_o[2*bsm_pkg::Width-1:bsm_pkg::Width] == '0)
    else $error("idle last step changed a zero accumulator");

endmodule
